// ===== sv/ils_pkg.sv =====
// Shared types and constants for the indexed list store.
package ils_pkg;

    localparam int DEFAULT_DEPTH = 16;
    localparam int ENTRY_W       = 32;
    localparam int POS_W         = 5;
    localparam int COUNT_OUT_W   = 5;

    typedef enum logic [2:0] {
        MODE_PUSH_BACK  = 3'd0,
        MODE_PUSH_FRONT = 3'd1,
        MODE_POP_FRONT  = 3'd2,
        MODE_POP_BACK   = 3'd3,
        MODE_INSERT     = 3'd4,
        MODE_REMOVE     = 3'd5,
        MODE_READ       = 3'd6,
        MODE_CLEAR      = 3'd7
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        SH_HOLD  = 2'd0,
        SH_OPEN  = 2'd1,
        SH_CLOSE = 2'd2
    } shift_op_t;

    typedef struct packed {
        shift_op_t          op;
        logic [ENTRY_W-1:0] value;
    } cell_ctrl_t;

endpackage

// ===== sv/ils_cell.sv =====
// One storage cell of the list, moving its entry to or from its neighbours.
module ils_cell #(
    parameter int DEPTH = ils_pkg::DEFAULT_DEPTH,
    parameter int INDEX = 0
) (
    input  logic                         aclk,
    input  ils_pkg::cell_ctrl_t          ctrl,
    input  logic [$clog2(DEPTH)-1:0]     idx,
    input  logic [ils_pkg::ENTRY_W-1:0]  left_data,
    input  logic [ils_pkg::ENTRY_W-1:0]  right_data,
    output logic [ils_pkg::ENTRY_W-1:0]  entry
);

    localparam int IW = $clog2(DEPTH);
    localparam logic [IW-1:0] MY_INDEX = IW'(INDEX);

    logic [ils_pkg::ENTRY_W-1:0] entry_reg;

    // Entries at or above the count hold stale data and are never read.
    always_ff @(posedge aclk) begin
        unique case (ctrl.op)
            ils_pkg::SH_OPEN: begin
                if (MY_INDEX > idx) begin
                    entry_reg <= left_data;
                end else if (MY_INDEX == idx) begin
                    entry_reg <= ctrl.value;
                end
            end
            ils_pkg::SH_CLOSE: begin
                if (MY_INDEX >= idx) begin
                    entry_reg <= right_data;
                end
            end
            default: begin
                entry_reg <= entry_reg;
            end
        endcase
    end

    assign entry = entry_reg;

endmodule

// ===== sv/indexed_list_store.sv =====
// Indexed list store: a row of cells holding an ordered list with a count.
// The result of a command is registered and shows in the cycle after acceptance.
// Throughput: one command per cycle while the result register is taken at once;
// the whole row of cells shifts in the accepting cycle, and the read mux sets the path.
// Reset clears the count and the result valid flag and holds s_ready low;
// entry contents are not cleared.
module indexed_list_store #(
    parameter int DEPTH = ils_pkg::DEFAULT_DEPTH
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [2:0]                        s_mode,
    input  logic [ils_pkg::POS_W-1:0]         s_position,
    input  logic signed [ils_pkg::ENTRY_W-1:0] s_item_value,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [1:0]                        m_status,
    output logic signed [ils_pkg::ENTRY_W-1:0] m_taken_value,
    output logic [ils_pkg::COUNT_OUT_W-1:0]   m_entry_count
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > ils_pkg::POS_W) ? CW : ils_pkg::POS_W;

    logic [CW-1:0]                  held_count_reg;
    logic [CW-1:0]                  count_next;
    logic                           m_valid_reg;
    ils_pkg::status_t               status_reg;
    ils_pkg::status_t               status_next;
    logic [ils_pkg::ENTRY_W-1:0]    taken_reg;
    logic [ils_pkg::ENTRY_W-1:0]    taken_next;
    logic [ils_pkg::COUNT_OUT_W-1:0] entry_count_reg;

    logic                           accept;
    logic                           full;
    logic                           empty;
    logic [PW-1:0]                  pos_ext;
    logic [PW-1:0]                  cnt_ext;
    logic [PW-1:0]                  cnt_next_ext;
    logic [PW-1:0]                  target_ext;
    logic [IW-1:0]                  target_idx;
    logic                           take_value;
    ils_pkg::shift_op_t             shift_op;
    ils_pkg::cell_ctrl_t            ctrl;
    logic [ils_pkg::ENTRY_W-1:0]    entry_q [DEPTH];

    assign accept  = s_valid && s_ready;
    assign s_ready = aresetn && (!m_valid_reg || m_ready);
    assign full    = (held_count_reg == CW'(DEPTH));
    assign empty   = (held_count_reg == '0);
    assign pos_ext = PW'(s_position);
    assign cnt_ext = PW'(held_count_reg);

    always_comb begin
        status_next = ils_pkg::ST_OK;
        shift_op    = ils_pkg::SH_HOLD;
        target_ext  = pos_ext;
        take_value  = 1'b0;
        count_next  = held_count_reg;
        unique case (ils_pkg::mode_t'(s_mode))
            ils_pkg::MODE_PUSH_BACK, ils_pkg::MODE_PUSH_FRONT: begin
                target_ext = (ils_pkg::mode_t'(s_mode) == ils_pkg::MODE_PUSH_BACK)
                             ? cnt_ext : '0;
                if (full) begin
                    status_next = ils_pkg::ST_FULL;
                end else begin
                    shift_op = ils_pkg::SH_OPEN;
                end
            end
            ils_pkg::MODE_POP_FRONT, ils_pkg::MODE_POP_BACK: begin
                target_ext = (ils_pkg::mode_t'(s_mode) == ils_pkg::MODE_POP_FRONT)
                             ? '0 : cnt_ext - PW'(1);
                if (empty) begin
                    status_next = ils_pkg::ST_EMPTY;
                end else begin
                    shift_op   = ils_pkg::SH_CLOSE;
                    take_value = 1'b1;
                end
            end
            ils_pkg::MODE_INSERT: begin
                if (full) begin
                    status_next = ils_pkg::ST_FULL;
                end else if (pos_ext > cnt_ext) begin
                    status_next = ils_pkg::ST_RANGE;
                end else begin
                    shift_op = ils_pkg::SH_OPEN;
                end
            end
            ils_pkg::MODE_REMOVE, ils_pkg::MODE_READ: begin
                if (empty) begin
                    status_next = ils_pkg::ST_EMPTY;
                end else if (pos_ext >= cnt_ext) begin
                    status_next = ils_pkg::ST_RANGE;
                end else begin
                    take_value = 1'b1;
                    if (ils_pkg::mode_t'(s_mode) == ils_pkg::MODE_REMOVE) begin
                        shift_op = ils_pkg::SH_CLOSE;
                    end
                end
            end
            default: begin
                count_next = '0;
            end
        endcase
        if (shift_op == ils_pkg::SH_OPEN) begin
            count_next = held_count_reg + CW'(1);
        end else if (shift_op == ils_pkg::SH_CLOSE) begin
            count_next = held_count_reg - CW'(1);
        end
    end

    // A target is only used on a successful command, where it lies below DEPTH.
    assign target_idx   = target_ext[IW-1:0];
    assign taken_next   = take_value ? entry_q[target_idx] : '0;
    assign cnt_next_ext = PW'(count_next);

    assign ctrl.op    = accept ? shift_op : ils_pkg::SH_HOLD;
    assign ctrl.value = s_item_value;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [ils_pkg::ENTRY_W-1:0] left_w;
        logic [ils_pkg::ENTRY_W-1:0] right_w;
        if (g == 0) begin : g_first
            assign left_w = entry_q[g];
        end else begin : g_inner_l
            assign left_w = entry_q[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign right_w = entry_q[g];
        end else begin : g_inner_r
            assign right_w = entry_q[g+1];
        end
        ils_cell #(
            .DEPTH (DEPTH),
            .INDEX (g)
        ) u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .idx        (target_idx),
            .left_data  (left_w),
            .right_data (right_w),
            .entry      (entry_q[g])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_count_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (accept) begin
                held_count_reg <= count_next;
                m_valid_reg    <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg      <= status_next;
            taken_reg       <= taken_next;
            entry_count_reg <= cnt_next_ext[ils_pkg::COUNT_OUT_W-1:0];
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = status_reg;
    assign m_taken_value = taken_reg;
    assign m_entry_count = entry_count_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        held_count_reg <= CW'(DEPTH))
        else $error("held count exceeds the list depth");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid)
        else $error("accepted transaction produced no result");

    a_fail_keeps_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && status_next != ils_pkg::ST_OK) |=> $stable(held_count_reg))
        else $error("failed command changed the count");

    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_mode == ils_pkg::MODE_CLEAR) |=> (held_count_reg == '0))
        else $error("clear left entries in the list");

    a_count_reported: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (m_entry_count == cnt_ext[ils_pkg::COUNT_OUT_W-1:0]))
        else $error("reported count differs from the held count");

endmodule
